// File: sv/rcsc_pkg.sv
// rcsc_pkg: shared types and constants of the receive channel scan controller.
// Used by rcsc_cfg_regs, rcsc_core and rx_channel_scan_controller_unit.
// No dependencies.
package rcsc_pkg;

    // Field widths
    localparam int CNT_W     = 24;
    localparam int FREQ_W    = 30;
    localparam int CFG_W     = 30;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_FREQ  = 4;

    localparam logic [CNT_W-1:0] CNT_MAX         = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] PRE_TIMEOUT_RST = 24'd100000;
    localparam logic [2:0]       CHAN_COUNT_RST  = 3'd1;

    // Radio mode, also the controller state
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_RX   = 3'd1,
        MODE_TX   = 3'd2,
        MODE_PRE  = 3'd3,
        MODE_PAY  = 3'd4
    } mode_t;

    // Action requested toward the radio
    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_CLEAR    = 3'd1,
        ACT_CLEAR_RX = 3'd2,
        ACT_READ     = 3'd3,
        ACT_RETUNE   = 3'd4
    } action_t;

    // Input word kinds
    typedef enum logic [1:0] {
        OP_LINE     = 2'd0,
        OP_TICK     = 2'd1,
        OP_TX_START = 2'd2,
        OP_TX_END   = 2'd3
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT = 3'd0,
        REG_SCAN_TIME     = 3'd1,
        REG_PRE_TIMEOUT   = 3'd2,
        REG_FREQ_CH0      = 3'd3,
        REG_FREQ_CH1      = 3'd4,
        REG_FREQ_CH2      = 3'd5,
        REG_FREQ_CH3      = 3'd6
    } reg_index_t;

    // Effective configuration seen by the core
    typedef struct packed {
        logic [2:0]                           chan_count;  // clamped, 1..MAX_CHANNELS
        logic [CNT_W-1:0]                     scan_us;     // zero already replaced
        logic [CNT_W-1:0]                     pre_timeout;
        logic [NUM_FREQ-1:0][FREQ_W-1:0]      freq;
    } cfg_t;

    // One input word
    typedef struct packed {
        opcode_t op;
        logic    preamble;
        logic    payload;
        logic    tx_ready;
    } item_t;

    // One result word
    typedef struct packed {
        mode_t              mode;
        action_t            action;
        logic [1:0]         channel;
        logic [FREQ_W-1:0]  frequency;
    } result_t;

endpackage

// File: sv/rcsc_cfg_regs.sv
// rcsc_cfg_regs: configuration register file with channel count clamp and
// default scan time substitution. Depends on rcsc_pkg.
module rcsc_cfg_regs #(
    parameter int MAX_CHANNELS    = 4,
    parameter int DEFAULT_SCAN_US = 10000
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rcsc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rcsc_pkg::CFG_W-1:0]            cfg_data,
    output rcsc_pkg::cfg_t                        cfg
);

    logic [2:0]                                         chan_count_reg;
    logic [rcsc_pkg::CNT_W-1:0]                         scan_reg;
    logic [rcsc_pkg::CNT_W-1:0]                         pre_timeout_reg;
    logic [rcsc_pkg::NUM_FREQ-1:0][rcsc_pkg::FREQ_W-1:0] freq_reg;

    logic [3:0] count_wide;

    // Register writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg  <= rcsc_pkg::CHAN_COUNT_RST;
            scan_reg        <= '0;
            pre_timeout_reg <= rcsc_pkg::PRE_TIMEOUT_RST;
            freq_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (rcsc_pkg::reg_index_t'(cfg_index))
                rcsc_pkg::REG_CHANNEL_COUNT: chan_count_reg  <= cfg_data[2:0];
                rcsc_pkg::REG_SCAN_TIME:     scan_reg        <= cfg_data[rcsc_pkg::CNT_W-1:0];
                rcsc_pkg::REG_PRE_TIMEOUT:   pre_timeout_reg <= cfg_data[rcsc_pkg::CNT_W-1:0];
                rcsc_pkg::REG_FREQ_CH0:      freq_reg[0]     <= cfg_data;
                rcsc_pkg::REG_FREQ_CH1:      freq_reg[1]     <= cfg_data;
                rcsc_pkg::REG_FREQ_CH2:      freq_reg[2]     <= cfg_data;
                rcsc_pkg::REG_FREQ_CH3:      freq_reg[3]     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp channel count: zero means one, cap at MAX_CHANNELS
    always_comb
    begin
        count_wide = {1'b0, chan_count_reg};
        if (count_wide == 4'd0)
            count_wide = 4'd1;
        if (count_wide > 4'(MAX_CHANNELS))
            count_wide = 4'(MAX_CHANNELS);
    end

    always_comb
    begin
        cfg.chan_count  = count_wide[2:0];
        cfg.scan_us     = (scan_reg == '0) ? rcsc_pkg::CNT_W'(DEFAULT_SCAN_US) : scan_reg;
        cfg.pre_timeout = pre_timeout_reg;
        cfg.freq        = freq_reg;
    end

endmodule

// File: sv/rcsc_core.sv
// rcsc_core: mode state machine, dwell and preamble counters, channel index.
// Works out one result per step from the registered input word. Depends on rcsc_pkg.
module rcsc_core #(
    parameter int MAX_CHANNELS   = 4,
    parameter int TICK_PERIOD_US = 100
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  rcsc_pkg::item_t      item,
    input  rcsc_pkg::cfg_t       cfg,
    output rcsc_pkg::result_t    result
);

    localparam int IDX_W  = $clog2(MAX_CHANNELS);
    localparam int TP_W   = $clog2(TICK_PERIOD_US + 1);
    localparam int PROD_W = rcsc_pkg::CNT_W + TP_W;

    rcsc_pkg::mode_t            mode_reg, mode_next;
    logic [rcsc_pkg::CNT_W-1:0] dwell_reg, dwell_next;
    logic [rcsc_pkg::CNT_W-1:0] pre_reg, pre_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    rcsc_pkg::action_t          action;

    logic [rcsc_pkg::CNT_W-1:0] dwell_inc, pre_inc;
    logic [PROD_W-1:0]          dwell_time, pre_time;
    logic [3:0]                 idx_plus;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= rcsc_pkg::MODE_IDLE;
            dwell_reg <= '0;
            pre_reg   <= '0;
            idx_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            dwell_reg <= dwell_next;
            pre_reg   <= pre_next;
            idx_reg   <= idx_next;
        end
    end

    // Saturating counts and elapsed time in us
    always_comb
    begin
        dwell_inc  = (dwell_reg == rcsc_pkg::CNT_MAX) ? dwell_reg : dwell_reg + 1'b1;
        pre_inc    = (pre_reg == rcsc_pkg::CNT_MAX) ? pre_reg : pre_reg + 1'b1;
        dwell_time = PROD_W'(dwell_inc) * PROD_W'(TICK_PERIOD_US);
        pre_time   = PROD_W'(pre_inc) * PROD_W'(TICK_PERIOD_US);
        idx_plus   = 4'(idx_reg) + 4'd1;
    end

    // Next mode
    always_comb
    begin
        mode_next = mode_reg;
        case (item.op)
            rcsc_pkg::OP_LINE:
            begin
                if (item.payload)
                    mode_next = rcsc_pkg::MODE_PAY;
                else if (item.preamble)
                    mode_next = rcsc_pkg::MODE_PRE;
                else
                    mode_next = rcsc_pkg::MODE_RX;
            end
            rcsc_pkg::OP_TICK:
            begin
                if (mode_reg == rcsc_pkg::MODE_PAY && item.tx_ready)
                    mode_next = rcsc_pkg::MODE_RX;
            end
            rcsc_pkg::OP_TX_START: mode_next = rcsc_pkg::MODE_TX;
            rcsc_pkg::OP_TX_END:
            begin
                if (mode_reg == rcsc_pkg::MODE_TX)
                    mode_next = rcsc_pkg::MODE_RX;
            end
            default: ;
        endcase
    end

    // Counters, channel index and action on ticks
    always_comb
    begin
        dwell_next = dwell_reg;
        pre_next   = pre_reg;
        idx_next   = idx_reg;
        action     = rcsc_pkg::ACT_NONE;
        if (item.op == rcsc_pkg::OP_TICK)
        begin
            case (mode_reg)
                rcsc_pkg::MODE_PAY:
                begin
                    if (item.tx_ready)
                        action = rcsc_pkg::ACT_CLEAR_RX;
                    else
                    begin
                        dwell_next = '0;
                        pre_next   = '0;
                        action     = rcsc_pkg::ACT_READ;
                    end
                end
                rcsc_pkg::MODE_PRE:
                begin
                    dwell_next = '0;
                    if (pre_time >= PROD_W'(cfg.pre_timeout))
                    begin
                        pre_next = '0;
                        action   = rcsc_pkg::ACT_CLEAR;
                    end
                    else
                        pre_next = pre_inc;
                end
                rcsc_pkg::MODE_RX:
                begin
                    if (dwell_time < PROD_W'(cfg.scan_us))
                        dwell_next = dwell_inc;
                    else
                    begin
                        dwell_next = '0;
                        if (cfg.chan_count != 3'd1)
                        begin
                            // wrap also catches an index left stale by a smaller count
                            idx_next = (idx_plus >= {1'b0, cfg.chan_count}) ?
                                       '0 : IDX_W'(idx_plus);
                            action   = rcsc_pkg::ACT_RETUNE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Result word from the updated state
    always_comb
    begin
        result.mode      = mode_next;
        result.action    = action;
        result.channel   = 2'(idx_next);
        result.frequency = (4'(idx_next) < 4'(rcsc_pkg::NUM_FREQ)) ?
                           cfg.freq[2'(idx_next)] : '0;
    end

endmodule

// File: sv/rx_channel_scan_controller_unit.sv
// Receive channel scan controller, top level.
// Path: a word accepted into the input register is worked out by the core and held in the result register.
// Throughput: one word per cycle while out_stall is low; the single compute stage between the input
// register and the result register sets it.
// Reset (rst_n, async, low): mode idle, counters and channel zero, registers to defaults.
// Depends on rcsc_pkg, rcsc_cfg_regs, rcsc_core.
module rx_channel_scan_controller_unit #(
    parameter int MAX_CHANNELS    = 4,
    parameter int TICK_PERIOD_US  = 100,
    parameter int DEFAULT_SCAN_US = 10000
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [rcsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rcsc_pkg::CFG_W-1:0]        cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        opcode,
    input  logic                              preamble_line,
    input  logic                              payload_line,
    input  logic                              tx_ready,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        mode,
    output logic [2:0]                        action,
    output logic [1:0]                        channel,
    output logic [rcsc_pkg::FREQ_W-1:0]       frequency
);

    rcsc_pkg::cfg_t    cfg;
    rcsc_pkg::item_t   item_reg;
    rcsc_pkg::result_t result, result_reg;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              in_accept, advance;

    rcsc_cfg_regs #(
        .MAX_CHANNELS    (MAX_CHANNELS),
        .DEFAULT_SCAN_US (DEFAULT_SCAN_US)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcsc_core #(
        .MAX_CHANNELS   (MAX_CHANNELS),
        .TICK_PERIOD_US (TICK_PERIOD_US)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Handshake: the input register moves on when the result register is free
    always_comb
    begin
        advance        = in_valid_reg && (!out_valid_reg || !out_stall);
        in_stall       = in_valid_reg && !advance;
        in_accept      = in_valid && !in_stall;
        in_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    // Control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input word register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.op       <= rcsc_pkg::opcode_t'(opcode);
            item_reg.preamble <= preamble_line;
            item_reg.payload  <= payload_line;
            item_reg.tx_ready <= tx_ready;
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign mode      = result_reg.mode;
    assign action    = result_reg.action;
    assign channel   = result_reg.channel;
    assign frequency = result_reg.frequency;

`ifndef SYNTH
    // an accepted word always lands in the input register
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_valid_reg)
        else $error("accepted word lost before compute stage");

    // input side stalls only when both registers are full and the output is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");

    // a computed word always reaches the result register
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("computed word lost");

    // action and resulting mode agree
    a_read_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == rcsc_pkg::ACT_READ)) |-> (mode == rcsc_pkg::MODE_PAY))
        else $error("packet read outside payload mode");

    a_rx_actions: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((action == rcsc_pkg::ACT_RETUNE) ||
                       (action == rcsc_pkg::ACT_CLEAR_RX))) |-> (mode == rcsc_pkg::MODE_RX))
        else $error("retune or clear to receive outside receive mode");

    a_clear_in_preamble: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == rcsc_pkg::ACT_CLEAR)) |-> (mode == rcsc_pkg::MODE_PRE))
        else $error("flag clear outside preamble mode");
`endif

endmodule
